/* rtl/core/rotation_matrix_to_quaternion_assert.svh */
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define RMQ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmq: implication failed");

// Consequent due a fixed number of cycles after the antecedent
`define RMQ_ASSERT_DELAY(label, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("rmq: delayed response missing");

`endif

/* rtl/core/rmq_pkg.sv */
package rmq_pkg;

    // The largest normalized magnitude sits in [2^29, 2^30)
    localparam int MAG_W  = 30;
    localparam int SQ_W   = 2 * MAG_W + 2;
    localparam int ROOT_W = SQ_W / 2;
    localparam int LANES  = 4;

    localparam int SAT_POS = 32767;
    localparam int SAT_NEG = 32768;

    typedef logic [LANES-1:0][MAG_W-1:0] rmq_mags_t;

    // Per-request sideband that rides along the pipeline
    typedef struct packed {
        logic [LANES-1:0] neg;
        logic             invalid;
    } rmq_tag_t;

endpackage

/* rtl/core/rmq_sqrt.sv */
module rmq_sqrt
    import rmq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [SQ_W-1:0]   in_rad,
    input  rmq_tag_t          in_tag,
    input  rmq_mags_t         in_mag,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output rmq_tag_t          out_tag,
    output rmq_mags_t         out_mag
);

    // One root bit per stage, digit-by-digit integer square root
    logic [63:0]       rem_reg  [ROOT_W];
    logic [63:0]       res_reg  [ROOT_W];
    logic [63:0]       rem_next [ROOT_W];
    logic [63:0]       res_next [ROOT_W];
    logic [63:0]       rem_src  [ROOT_W];
    logic [63:0]       res_src  [ROOT_W];
    logic [63:0]       trial    [ROOT_W];
    rmq_tag_t          tag_reg  [ROOT_W];
    rmq_mags_t         mag_reg  [ROOT_W];
    logic [ROOT_W-1:0] vld_reg;

    // Select each stage's source
    always_comb
    begin
        rem_src[0] = {{(64-SQ_W){1'b0}}, in_rad};
        res_src[0] = '0;
        for (int i = 1; i < ROOT_W; i++)
        begin
            rem_src[i] = rem_reg[i-1];
            res_src[i] = res_reg[i-1];
        end
    end

    // Try the stage's bit against the remainder
    always_comb
    begin
        for (int i = 0; i < ROOT_W; i++)
        begin
            trial[i] = res_src[i] + (64'd1 << (2 * (ROOT_W - 1 - i)));
            if (rem_src[i] >= trial[i])
            begin
                rem_next[i] = rem_src[i] - trial[i];
                res_next[i] = (res_src[i] >> 1) + (64'd1 << (2 * (ROOT_W - 1 - i)));
            end
            else
            begin
                rem_next[i] = rem_src[i];
                res_next[i] = res_src[i] >> 1;
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[ROOT_W-2:0], in_valid};
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        res_reg    <= res_next;
        tag_reg[0] <= in_tag;
        mag_reg[0] <= in_mag;
        for (int i = 1; i < ROOT_W; i++)
        begin
            tag_reg[i] <= tag_reg[i-1];
            mag_reg[i] <= mag_reg[i-1];
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_root  = res_reg[ROOT_W-1][ROOT_W-1:0];
    assign out_tag   = tag_reg[ROOT_W-1];
    assign out_mag   = mag_reg[ROOT_W-1];

endmodule

/* rtl/core/rmq_div.sv */
module rmq_div
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = 14
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic [ROOT_W-1:0]                in_root,
    input  rmq_tag_t                         in_tag,
    input  rmq_mags_t                        in_mag,
    output logic                             out_valid,
    output logic [LANES-1:0][FRAC_BITS+1:0]  out_q,
    output rmq_tag_t                         out_tag
);

    localparam int QB = FRAC_BITS + 2;
    localparam int DW = FRAC_BITS + 32;

    // One quotient bit per stage, four lanes share the divisor
    logic [LANES-1:0][DW-1:0] rem_reg  [QB];
    logic [LANES-1:0][QB-1:0] q_reg    [QB];
    logic [ROOT_W-1:0]        root_reg [QB];
    rmq_tag_t                 tag_reg  [QB];
    logic [QB-1:0]            vld_reg;

    logic [LANES-1:0][DW-1:0] rem_src  [QB];
    logic [LANES-1:0][QB-1:0] q_src    [QB];
    logic [ROOT_W-1:0]        root_src [QB];
    logic [LANES-1:0][DW-1:0] rem_next [QB];
    logic [LANES-1:0][QB-1:0] q_next   [QB];
    logic [DW-1:0]            dsh      [QB];

    // Build numerators with half the divisor for rounding
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            rem_src[0][l] = (DW'(in_mag[l]) << FRAC_BITS) + DW'(in_root >> 1);
            q_src[0][l]   = '0;
        end
        root_src[0] = in_root;
        for (int j = 1; j < QB; j++)
        begin
            rem_src[j]  = rem_reg[j-1];
            q_src[j]    = q_reg[j-1];
            root_src[j] = root_reg[j-1];
        end
    end

    // Restoring step: subtract the shifted divisor where it fits
    always_comb
    begin
        for (int j = 0; j < QB; j++)
        begin
            dsh[j] = DW'(root_src[j]) << (QB - 1 - j);
            for (int l = 0; l < LANES; l++)
            begin
                if (rem_src[j][l] >= dsh[j])
                begin
                    rem_next[j][l] = rem_src[j][l] - dsh[j];
                    q_next[j][l]   = {q_src[j][l][QB-2:0], 1'b1};
                end
                else
                begin
                    rem_next[j][l] = rem_src[j][l];
                    q_next[j][l]   = {q_src[j][l][QB-2:0], 1'b0};
                end
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[QB-2:0], in_valid};
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        root_reg   <= root_src;
        tag_reg[0] <= in_tag;
        for (int j = 1; j < QB; j++)
            tag_reg[j] <= tag_reg[j-1];
    end

    assign out_valid = vld_reg[QB-1];
    assign out_q     = q_reg[QB-1];
    assign out_tag   = tag_reg[QB-1];

endmodule

/* rtl/core/rotation_matrix_to_quaternion.sv */
// Rotation matrix to unit quaternion (Shepperd's method) in signed fixed
// point with FRAC_BITS fraction bits. Fully pipelined: busy stays low and a
// new request may be started every cycle. Each request yields one result,
// flagged by done; the receiver cannot stall, so results must be taken as
// they come. The pipeline holds five front stages (vector build, leading
// one, normalize, square, sum), a 31-stage square root and a FRAC_BITS + 2
// stage divider shared by the four components, plus the output register.
// A matrix whose radicand is not positive returns zeros with invalid set.
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = 14
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] m00,
    input  logic signed [15:0] m01,
    input  logic signed [15:0] m02,
    input  logic signed [15:0] m10,
    input  logic signed [15:0] m11,
    input  logic signed [15:0] m12,
    input  logic signed [15:0] m20,
    input  logic signed [15:0] m21,
    input  logic signed [15:0] m22,
    output logic               done,
    output logic signed [15:0] qx,
    output logic signed [15:0] qy,
    output logic signed [15:0] qz,
    output logic signed [15:0] qw,
    output logic               invalid
);

    localparam int VW = ((FRAC_BITS >= 17) ? FRAC_BITS : 17) + 2;
    localparam int MW = VW - 1;
    localparam int QB = FRAC_BITS + 2;
    localparam int QW = (QB > 17) ? QB : 17;
    localparam logic signed [VW-1:0] ONE = VW'(64'd1 << FRAC_BITS);

    // Stage 1: build the scaled vector
    logic signed [VW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
    logic signed [VW-1:0] tr_c, r_c;
    logic signed [VW-1:0] v_c [LANES];
    logic [LANES-1:0][MW-1:0] mag1_next;
    rmq_tag_t tag1_next;

    assign a00 = VW'(m00);
    assign a01 = VW'(m01);
    assign a02 = VW'(m02);
    assign a10 = VW'(m10);
    assign a11 = VW'(m11);
    assign a12 = VW'(m12);
    assign a20 = VW'(m20);
    assign a21 = VW'(m21);
    assign a22 = VW'(m22);
    assign tr_c = a00 + a11 + a22;

    always_comb
    begin
        if (tr_c > 0)
        begin
            r_c    = ONE + tr_c;
            v_c[0] = a21 - a12;
            v_c[1] = a02 - a20;
            v_c[2] = a10 - a01;
            v_c[3] = r_c;
        end
        else if (a00 > a11 && a00 > a22)
        begin
            r_c    = ONE + a00 - a11 - a22;
            v_c[0] = r_c;
            v_c[1] = a01 + a10;
            v_c[2] = a02 + a20;
            v_c[3] = a21 - a12;
        end
        else if (a11 > a22)
        begin
            r_c    = ONE - a00 + a11 - a22;
            v_c[0] = a01 + a10;
            v_c[1] = r_c;
            v_c[2] = a12 + a21;
            v_c[3] = a02 - a20;
        end
        else
        begin
            r_c    = ONE - a00 - a11 + a22;
            v_c[0] = a02 + a20;
            v_c[1] = a12 + a21;
            v_c[2] = r_c;
            v_c[3] = a10 - a01;
        end
        tag1_next.invalid = (r_c <= 0);
        for (int l = 0; l < LANES; l++)
        begin
            tag1_next.neg[l] = v_c[l][VW-1];
            mag1_next[l]     = v_c[l][VW-1] ? MW'(-v_c[l]) : MW'(v_c[l]);
        end
    end

    logic [LANES-1:0][MW-1:0] mag1_reg, mag2_reg;
    rmq_tag_t tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg;
    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg, vld5_reg;

    // Stage 2: leading one of the largest magnitude
    logic [MW-1:0] or_c;
    logic [4:0]    lead2_next, lead2_reg;

    always_comb
    begin
        or_c       = mag1_reg[0] | mag1_reg[1] | mag1_reg[2] | mag1_reg[3];
        lead2_next = '0;
        for (int i = 0; i < MW; i++)
        begin
            if (or_c[i])
                lead2_next = 5'(i);
        end
    end

    // Stage 3: shift all magnitudes by one common amount
    rmq_mags_t mag3_next, mag3_reg, mag4_reg, mag5_reg;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (lead2_reg >= 5'(MAG_W - 1))
                mag3_next[l] = MAG_W'(mag2_reg[l] >> (lead2_reg - 5'(MAG_W - 1)));
            else
                mag3_next[l] = MAG_W'({{(64-MW){1'b0}}, mag2_reg[l]}
                                      << (5'(MAG_W - 1) - lead2_reg));
        end
    end

    // Stage 4: square each lane
    logic [LANES-1:0][2*MAG_W-1:0] sq4_next, sq4_reg;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            sq4_next[l] = (2*MAG_W)'(mag3_reg[l]) * (2*MAG_W)'(mag3_reg[l]);
    end

    // Stage 5: sum of squares
    logic [SQ_W-1:0] rad5_next, rad5_reg;

    assign rad5_next = SQ_W'(sq4_reg[0]) + SQ_W'(sq4_reg[1])
                     + SQ_W'(sq4_reg[2]) + SQ_W'(sq4_reg[3]);

    // Hold front-end valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= start & ~busy;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
            vld5_reg <= vld4_reg;
        end
    end

    // Advance front-end payload
    always_ff @(posedge clk)
    begin
        mag1_reg  <= mag1_next;
        tag1_reg  <= tag1_next;
        mag2_reg  <= mag1_reg;
        lead2_reg <= lead2_next;
        tag2_reg  <= tag1_reg;
        mag3_reg  <= mag3_next;
        tag3_reg  <= tag2_reg;
        sq4_reg   <= sq4_next;
        mag4_reg  <= mag3_reg;
        tag4_reg  <= tag3_reg;
        rad5_reg  <= rad5_next;
        mag5_reg  <= mag4_reg;
        tag5_reg  <= tag4_reg;
    end

    // Norm
    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    rmq_tag_t          sq_tag;
    rmq_mags_t         sq_mag;

    rmq_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld5_reg),
        .in_rad    (rad5_reg),
        .in_tag    (tag5_reg),
        .in_mag    (mag5_reg),
        .out_valid (sq_vld),
        .out_root  (sq_root),
        .out_tag   (sq_tag),
        .out_mag   (sq_mag)
    );

    // Divide each lane by the norm
    logic                         dv_vld;
    logic [LANES-1:0][QB-1:0]     dv_q;
    rmq_tag_t                     dv_tag;

    rmq_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_vld),
        .in_root   (sq_root),
        .in_tag    (sq_tag),
        .in_mag    (sq_mag),
        .out_valid (dv_vld),
        .out_q     (dv_q),
        .out_tag   (dv_tag)
    );

    // Apply sign, saturate, drop invalid results to zero
    logic [QW-1:0]          qe    [LANES];
    logic [LANES-1:0][15:0] q_next;
    logic [LANES-1:0][15:0] q_reg;
    logic                   done_reg, invalid_reg;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            qe[l] = QW'(dv_q[l]);
            if (dv_tag.invalid)
                q_next[l] = '0;
            else if (dv_tag.neg[l])
                q_next[l] = (qe[l] > QW'(SAT_NEG)) ? 16'h8000 : 16'(-qe[l]);
            else
                q_next[l] = (qe[l] > QW'(SAT_POS)) ? 16'h7FFF : qe[l][15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_vld;
    end

    always_ff @(posedge clk)
    begin
        q_reg       <= q_next;
        invalid_reg <= dv_tag.invalid;
    end

    assign busy    = 1'b0;
    assign done    = done_reg;
    assign qx      = q_reg[0];
    assign qy      = q_reg[1];
    assign qz      = q_reg[2];
    assign qw      = q_reg[3];
    assign invalid = invalid_reg;

endmodule

/* rtl/core/rmq_checker.sv */
`include "rotation_matrix_to_quaternion_assert.svh"

module rmq_checker
#(
    parameter int FRAC_BITS = 14
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [15:0] qx,
    input logic signed [15:0] qy,
    input logic signed [15:0] qz,
    input logic signed [15:0] qw,
    input logic               invalid
);

    localparam int LAT = FRAC_BITS + 39;

    // Every request comes back after the fixed latency
    `RMQ_ASSERT_DELAY(a_latency, start && !busy, LAT, done)

    // Rejected matrices return a zero quaternion
    `RMQ_ASSERT_IMPL(a_invalid_zero, done && invalid, qx == 0 && qy == 0 && qz == 0 && qw == 0)

    // A valid result always has at least one nonzero component
    `RMQ_ASSERT_IMPL(a_valid_nonzero, done && !invalid, qx != 0 || qy != 0 || qz != 0 || qw != 0)

endmodule

bind rotation_matrix_to_quaternion rmq_checker #(.FRAC_BITS(FRAC_BITS)) u_rmq_checker (.*);

/* tb/sv/tb_rotation_matrix_to_quaternion.sv */
module tb_rotation_matrix_to_quaternion;

    localparam int FRAC = 14;
    localparam int ONE  = 1 << FRAC;
    localparam int LAT  = 39 + FRAC;

    typedef struct {
        logic signed [15:0] m [9];
    } matrix_t;

    typedef struct {
        logic signed [15:0] q [4];
        logic               bad;
    } quat_t;

    // one directed row: matrix plus optional typed-in answer
    typedef struct {
        matrix_t mat;
        bit      known;
        quat_t   ans;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] m00 = '0, m01 = '0, m02 = '0, m10 = '0, m11 = '0;
    logic signed [15:0] m12 = '0, m20 = '0, m21 = '0, m22 = '0;
    logic               done;
    logic signed [15:0] qx, qy, qz, qw;
    logic               invalid;

    quat_t   quat_fifo [$];
    int      n_err = 0;
    int      n_sent = 0;
    int      n_got = 0;
    int      n_bad = 0;

    rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11),
        .m12(m12), .m20(m20), .m21(m21), .m22(m22),
        .done(done), .qx(qx), .qy(qy), .qz(qz), .qw(qw), .invalid(invalid)
    );

    always #1 clk = ~clk;

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned lo, hi, mid;
        lo = 0;
        hi = 64'd4294967296;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= n) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    // Shepperd branch select, normalize, round and saturate
    function automatic quat_t shepperd_quat(matrix_t a);
        quat_t           res;
        longint          e [9];
        longint          v [4];
        longint          rad;
        longint unsigned mag [4];
        longint unsigned top, sum, nrm, qq;
        for (int i = 0; i < 9; i++) e[i] = a.m[i];
        if (e[0] + e[4] + e[8] > 0)
        begin
            rad = ONE + e[0] + e[4] + e[8];
            v = '{e[7] - e[5], e[2] - e[6], e[3] - e[1], rad};
        end
        else if (e[0] > e[4] && e[0] > e[8])
        begin
            rad = ONE + e[0] - e[4] - e[8];
            v = '{rad, e[1] + e[3], e[2] + e[6], e[7] - e[5]};
        end
        else if (e[4] > e[8])
        begin
            rad = ONE - e[0] + e[4] - e[8];
            v = '{e[1] + e[3], rad, e[5] + e[7], e[2] - e[6]};
        end
        else
        begin
            rad = ONE - e[0] - e[4] + e[8];
            v = '{e[2] + e[6], e[5] + e[7], rad, e[3] - e[1]};
        end
        res.bad = 1'b0;
        if (rad <= 0)
        begin
            res.q = '{0, 0, 0, 0};
            res.bad = 1'b1;
            return res;
        end
        top = 0;
        for (int i = 0; i < 4; i++)
        begin
            mag[i] = v[i] < 0 ? -v[i] : v[i];
            if (mag[i] > top) top = mag[i];
        end
        while (top < (64'd1 << 29))
        begin
            top <<= 1;
            for (int i = 0; i < 4; i++) mag[i] <<= 1;
        end
        while (top >= (64'd1 << 30))
        begin
            top >>= 1;
            for (int i = 0; i < 4; i++) mag[i] >>= 1;
        end
        sum = 0;
        for (int i = 0; i < 4; i++) sum += mag[i] * mag[i];
        nrm = root_floor(sum);
        for (int i = 0; i < 4; i++)
        begin
            qq = ((mag[i] << FRAC) + (nrm >> 1)) / nrm;
            if (v[i] < 0) res.q[i] = qq > 32768 ? -16'sd32768 : 16'(-$signed(17'(qq)));
            else res.q[i] = qq > 32767 ? 16'sd32767 : 16'(qq);
        end
        return res;
    endfunction

    function automatic matrix_t mk(int a0, int a1, int a2, int a3, int a4,
                                   int a5, int a6, int a7, int a8);
        matrix_t r;
        r.m = '{16'(a0), 16'(a1), 16'(a2), 16'(a3), 16'(a4),
                16'(a5), 16'(a6), 16'(a7), 16'(a8)};
        return r;
    endfunction

    // random rotation-like matrix: signed permutation with noise
    function automatic matrix_t rand_rot();
        matrix_t r;
        int      perm [3];
        int      k, spread;
        perm = '{0, 1, 2};
        for (int i = 2; i > 0; i--)
        begin
            k = $urandom_range(i);
            {perm[i], perm[k]} = {perm[k], perm[i]};
        end
        spread = $urandom_range(3) == 0 ? 16000 : 3000;
        for (int i = 0; i < 9; i++)
            r.m[i] = 16'($signed($urandom_range(2 * spread)) - spread);
        for (int i = 0; i < 3; i++)
            r.m[3 * i + perm[i]] = $urandom_range(1) ? 16'sd16384 - r.m[3 * i + perm[i]] / 4
                                                     : -16'sd16384 + r.m[3 * i + perm[i]] / 4;
        return r;
    endfunction

    function automatic matrix_t rand_any();
        matrix_t r;
        for (int i = 0; i < 9; i++) r.m[i] = 16'($urandom);
        return r;
    endfunction

    // hold a request until accepted; the caller drops start when idling
    task automatic issue(matrix_t a);
        {m00, m01, m02, m10, m11, m12, m20, m21, m22} <=
            {a.m[0], a.m[1], a.m[2], a.m[3], a.m[4], a.m[5], a.m[6], a.m[7], a.m[8]};
        start <= 1'b1;
        do @(posedge clk); while (busy);
        quat_fifo.push_back(shepperd_quat(a));
        n_sent++;
    endtask

    task automatic issue_known(dir_row_t row);
        quat_t p;
        issue(row.mat);
        if (row.known)
        begin
            p = quat_fifo[$];
            if (p.q != row.ans.q || p.bad != row.ans.bad)
            begin
                $error("directed row %0d: predictor disagrees with typed answer", n_sent);
                n_err++;
            end
        end
    endtask

    // check each strobed result against the oldest expectation
    always @(posedge clk)
    begin
        quat_t exp_q;
        if (rst_n && done)
        begin
            n_got++;
            if (quat_fifo.size() == 0)
            begin
                $error("result with no request outstanding");
                n_err++;
            end
            else
            begin
                exp_q = quat_fifo.pop_front();
                if (exp_q.bad) n_bad++;
                if (qx !== exp_q.q[0])
                begin
                    $error("qx exp %0d got %0d", exp_q.q[0], qx);
                    n_err++;
                end
                if (qy !== exp_q.q[1])
                begin
                    $error("qy exp %0d got %0d", exp_q.q[1], qy);
                    n_err++;
                end
                if (qz !== exp_q.q[2])
                begin
                    $error("qz exp %0d got %0d", exp_q.q[2], qz);
                    n_err++;
                end
                if (qw !== exp_q.q[3])
                begin
                    $error("qw exp %0d got %0d", exp_q.q[3], qw);
                    n_err++;
                end
                if (invalid !== exp_q.bad)
                begin
                    $error("invalid exp %0d got %0d", exp_q.bad, invalid);
                    n_err++;
                end
            end
        end
    end

    initial
    begin
        dir_row_t rows [$];
        dir_row_t row;
        matrix_t  mt;
        int       gap, burst;
        quat_t    idq;
        idq.q = '{0, 0, 0, 16384};
        idq.bad = 1'b0;

        // identity, branch picks, diagonal extremes that fall to the z branch
        row.known = 1; row.ans = idq;
        row.mat = mk(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE); rows.push_back(row);
        row.ans.q = '{16384, 0, 0, 0};
        row.mat = mk(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE); rows.push_back(row);
        row.ans.q = '{0, 16384, 0, 0};
        row.mat = mk(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE); rows.push_back(row);
        row.ans.q = '{0, 0, 16384, 0};
        row.mat = mk(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE); rows.push_back(row);
        row.mat = mk(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768); rows.push_back(row);
        row.mat = mk(0, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
        row.mat = mk(-ONE, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
        row.known = 0;
        row.mat = mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        rows.push_back(row);
        row.mat = mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 0);
        rows.push_back(row);
        row.mat = mk(0, 11585, 0, -11585, 0, 0, 0, 0, ONE); rows.push_back(row);
        row.mat = mk(0, -32768, 32767, 32767, 0, -32768, -32768, 32767, 1); rows.push_back(row);
        row.mat = mk(1, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
        row.mat = mk(-2, 0, 0, 0, 1, 0, 0, 0, 1); rows.push_back(row);
        row.mat = mk(5, 0, 0, 0, 5, 0, 0, 0, 5); rows.push_back(row);
        row.mat = mk(-32768, 5, -7, 9, -32768, 3, 1, 2, 32767); rows.push_back(row);
        row.mat = mk(32767, 32767, -32768, 32767, -32768, -32768, 32767, 32767, -32768);
        rows.push_back(row);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i]) issue_known(rows[i]);

        // wait for the pipe to drain once
        start <= 1'b0;
        while (quat_fifo.size() != 0) @(posedge clk);

        // random bursts of mostly rotation-like matrices
        while (n_sent < 800)
        begin
            burst = $urandom_range(3) == 0 ? $urandom_range(40, 10) : $urandom_range(6, 1);
            for (int b = 0; b < burst; b++)
            begin
                mt = $urandom_range(9) < 7 ? rand_rot() : rand_any();
                issue(mt);
            end
            gap = $urandom_range(3) == 0 ? 0 : $urandom_range(8);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        start <= 1'b0;

        while (quat_fifo.size() != 0) @(posedge clk);
        repeat (LAT + 10) @(posedge clk);
        $display("Sent %0d matrices, %0d results checked, %0d with invalid radicand.",
                 n_sent, n_got, n_bad);
        if (n_err == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #200000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
